/* hdl/mexp_pkg.sv */
package mexp_pkg;

  localparam int unsigned WORD_WIDTH = 17;
  // product word: 2r + b stays below 3m
  localparam int unsigned PROD_W = WORD_WIDTH + 2;
  localparam int unsigned CNT_W = $clog2(WORD_WIDTH);
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_EXPONENT = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_MODULUS = REG_IDX_W'(1);

  localparam logic [WORD_WIDTH-1:0] EXPONENT_RST = WORD_WIDTH'(7);
  localparam logic [WORD_WIDTH-1:0] MODULUS_RST = WORD_WIDTH'(2);

  typedef struct packed {
    logic                  start;
    logic [WORD_WIDTH-1:0] a;
    logic [WORD_WIDTH-1:0] b;
  } mexp_mul_req_t;

  typedef struct packed {
    logic                  done;
    logic [WORD_WIDTH-1:0] prod;
  } mexp_mul_rsp_t;

endpackage

/* hdl/modular_exponentiation.sv */
// modular exponentiation: power_mod = base ** exponent mod modulus
// config: cfg_we_i writes cfg_data_i into register cfg_idx_i at the clock
//   edge (0 exponent, 1 modulus); other indexes are ignored. write only
//   while busy is low. reset gives exponent 7 and modulus 2.
// input: an item is taken at a clock edge with start high and busy low.
//   busy stays high until the result is out.
// output: power_mod_o is valid for exactly one cycle with done_o high.
//   the receiver cannot stall, so it must capture the result that cycle.
//   start may be raised again in the cycle done_o is high.
// datapath: one shared shift-and-subtract modular multiplier does all the
//   work. the base is reduced first, then square-and-multiply runs lsb
//   first, stopping at the top set exponent bit. a modulus below two
//   gives 0 in the cycle after the accept, so such items can follow back
//   to back.
// reset clears the sequencer; an item in flight is dropped.
module modular_exponentiation
  import mexp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [WORD_WIDTH-1:0] cfg_data_i,
  input  logic                  start,
  output logic                  busy,
  input  logic [WORD_WIDTH-1:0] base_i,
  output logic                  done_o,
  output logic [WORD_WIDTH-1:0] power_mod_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RED,
    ST_MUL,
    ST_SQR
  } state_e;

  state_e                state_q;
  logic [WORD_WIDTH-1:0] exp_q;
  logic [WORD_WIDTH-1:0] mod_q;
  logic [WORD_WIDTH-1:0] e_q;
  logic [WORD_WIDTH-1:0] acc_q;
  logic [WORD_WIDTH-1:0] sq_q;
  logic [WORD_WIDTH-1:0] res_q;
  logic                  done_q;
  mexp_mul_req_t         req_q;
  mexp_mul_rsp_t         rsp;

  logic [WORD_WIDTH-1:0] ev_e;
  logic [WORD_WIDTH-1:0] e_rest;
  logic                  mod_small;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= EXPONENT_RST;
      mod_q <= MODULUS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_EXPONENT: exp_q <= cfg_data_i;
        REG_MODULUS:  mod_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign mod_small = (mod_q < WORD_WIDTH'(2));
  // exponent bits still to handle when choosing the next multiply
  assign ev_e      = (state_q == ST_SQR) ? (e_q >> 1) : e_q;
  assign e_rest    = e_q >> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      done_q    <= 1'b0;
      req_q     <= '0;
      e_q       <= '0;
      acc_q     <= '0;
      sq_q      <= '0;
      res_q     <= '0;
    end else begin
      done_q      <= 1'b0;
      req_q.start <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            e_q   <= exp_q;
            acc_q <= WORD_WIDTH'(1);
            if (mod_small) begin
              res_q  <= '0;
              done_q <= 1'b1;
            end else begin
              // base * 1 mod m reduces any base
              req_q.start <= 1'b1;
              req_q.a     <= base_i;
              req_q.b     <= WORD_WIDTH'(1);
              state_q     <= ST_RED;
            end
          end
        end
        ST_RED, ST_SQR: begin
          if (rsp.done) begin
            sq_q <= rsp.prod;
            e_q  <= ev_e;
            if (ev_e == '0) begin
              res_q   <= acc_q;
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end else if (ev_e[0]) begin
              req_q.start <= 1'b1;
              req_q.a     <= acc_q;
              req_q.b     <= rsp.prod;
              state_q     <= ST_MUL;
            end else begin
              req_q.start <= 1'b1;
              req_q.a     <= rsp.prod;
              req_q.b     <= rsp.prod;
              state_q     <= ST_SQR;
            end
          end
        end
        ST_MUL: begin
          if (rsp.done) begin
            acc_q <= rsp.prod;
            if (e_rest == '0) begin
              res_q   <= rsp.prod;
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              req_q.start <= 1'b1;
              req_q.a     <= sq_q;
              req_q.b     <= sq_q;
              state_q     <= ST_SQR;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  mexp_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_q),
    .mod_i  (mod_q),
    .rsp_o  (rsp)
  );

  assign busy        = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign power_mod_o = res_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while sequencer busy");

  a_launch_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !mod_small) |=> (state_q == ST_RED && req_q.start))
    else $error("accepted item did not launch base reduction");

  a_rsp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q != ST_IDLE))
    else $error("multiplier finished while sequencer idle");

  a_res_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (power_mod_o < mod_q || mod_small))
    else $error("result not reduced below modulus");

endmodule

/* hdl/mexp_modmul.sv */
module mexp_modmul
  import mexp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mexp_mul_req_t         req_i,
  input  logic [WORD_WIDTH-1:0] mod_i,
  output mexp_mul_rsp_t         rsp_o
);

  typedef enum logic {
    MM_IDLE,
    MM_RUN
  } mm_state_e;

  mm_state_e             state_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [WORD_WIDTH-1:0] a_q;
  logic [WORD_WIDTH-1:0] b_q;
  logic [WORD_WIDTH-1:0] r_q;
  logic [WORD_WIDTH-1:0] r_d;
  logic                  done_q;

  logic [PROD_W-1:0] t;
  logic [PROD_W-1:0] m1;
  logic [PROD_W-1:0] m2;
  logic [PROD_W-1:0] t_m1;
  logic [PROD_W-1:0] t_m2;

  // one multiplier bit per cycle, msb first, operand b must be below the modulus
  always_comb begin
    m1   = {2'b00, mod_i};
    m2   = {1'b0, mod_i, 1'b0};
    t    = {1'b0, r_q, 1'b0} + (a_q[WORD_WIDTH-1] ? {2'b00, b_q} : '0);
    t_m1 = t - m1;
    t_m2 = t - m2;
    if (t >= m2) begin
      r_d = t_m2[WORD_WIDTH-1:0];
    end else if (t >= m1) begin
      r_d = t_m1[WORD_WIDTH-1:0];
    end else begin
      r_d = t[WORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MM_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      a_q     <= '0;
      b_q     <= '0;
      r_q     <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        MM_IDLE: begin
          if (req_i.start) begin
            a_q     <= req_i.a;
            b_q     <= req_i.b;
            r_q     <= '0;
            cnt_q   <= CNT_W'(WORD_WIDTH - 1);
            state_q <= MM_RUN;
          end
        end
        MM_RUN: begin
          r_q <= r_d;
          a_q <= {a_q[WORD_WIDTH-2:0], 1'b0};
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            done_q  <= 1'b1;
            state_q <= MM_IDLE;
          end
        end
        default: begin
          state_q <= MM_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = r_q;

endmodule
